// File: rtl/imavg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imavg_pkg
// Shared types and constants for the IMU moving-average / gyro-bias core.
// ----------------------------------------------------------------------------
package imavg_pkg;

    localparam int SMP_W              = 16;
    localparam int AXES               = 6;
    localparam int GYRO_AXES          = 3;
    localparam int GYRO_BASE          = 3;
    localparam int CNT_W              = 8;
    localparam int WINDOW_LEN_DEF     = 10;
    localparam int CAL_SAMPLES_DEF    = 100;
    localparam int WARMUP_SAMPLES_DEF = 60;

    typedef logic signed [SMP_W-1:0] t_smp;
    typedef t_smp t_axes [AXES];

    typedef enum logic [1:0] {
        PH_WARM,
        PH_CAL,
        PH_DONE
    } t_phase;

    // per-transaction calibration tags, carried down the pipeline
    typedef struct packed {
        logic clear;
        logic cal;
        logic last;
        logic bvalid;
    } t_tag;

endpackage
`default_nettype wire

// File: rtl/imavg_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imavg_cell
// One window cell: holds one sample per axis and passes it to its neighbor.
// ----------------------------------------------------------------------------
module imavg_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire imavg_pkg::t_axes i_smp,
    output imavg_pkg::t_axes     o_smp
);
    import imavg_pkg::*;

    t_axes r_smp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXES; k++) begin
                r_smp[k] <= '0;
            end
        end else if (i_en) begin
            r_smp <= i_smp;
        end
    end

    assign o_smp = r_smp;

endmodule
`default_nettype wire

// File: rtl/imavg_cdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imavg_cdiv
// Signed divide by a constant, truncating toward zero. Reciprocal multiply
// registered, shift and sign restore after the register.
// ----------------------------------------------------------------------------
module imavg_cdiv #(
    parameter int IN_W  = 20,
    parameter int OUT_W = 16,
    parameter int DIV   = 10
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [IN_W-1:0]  i_num,
    output logic signed [OUT_W-1:0]      o_quo
);
    localparam int SHIFT = IN_W + $clog2(DIV);
    localparam int R_W   = IN_W + 1;
    localparam int P_W   = IN_W + R_W;
    localparam int Q_W   = P_W - SHIFT;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [R_W-1:0] RECIP = R_W'(RECIP64);

    logic [IN_W-1:0] w_mag;
    logic [P_W-1:0]  r_prod;
    logic            r_neg;
    logic [Q_W-1:0]  w_q;

    assign w_mag = i_num[IN_W-1] ? (IN_W'(0) - i_num) : i_num;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= P_W'(w_mag) * P_W'(RECIP);
            r_neg  <= i_num[IN_W-1];
        end
    end

    assign w_q   = r_prod[P_W-1:SHIFT];
    assign o_quo = r_neg ? (OUT_W'(0) - OUT_W'(w_q)) : OUT_W'(w_q);

endmodule
`default_nettype wire

// File: rtl/imu_moving_average_gyro_bias_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_moving_average_gyro_bias_core
// Six-axis moving-average smoother with gyro bias calibration.
//
// Slave stream carries one six-axis sample per transaction, recalibrate in
// tuser. Master stream returns one result per transaction: window means for
// the accelerometer, bias-corrected window means for the gyro, bias_valid in
// tuser. A row of WINDOW_LEN cells holds the sample history; running sums feed
// reciprocal-multiply dividers.
// Throughput is one transaction per cycle while the output is not stalled,
// through a five-stage pipe of running sums and divider multipliers. The bias
// divider completes within the same pipe, so new biases apply from the next
// transaction.
// Reset clears windows, sums, biases and calibration, and restarts warm-up.
// The whole pipe advances only while the output register is empty or being
// taken, so a stalled receiver holds s_axis_tready low and loses nothing.
// ----------------------------------------------------------------------------
module imu_moving_average_gyro_bias_core #(
    parameter int WINDOW_LEN     = imavg_pkg::WINDOW_LEN_DEF,
    parameter int CAL_SAMPLES    = imavg_pkg::CAL_SAMPLES_DEF,
    parameter int WARMUP_SAMPLES = imavg_pkg::WARMUP_SAMPLES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
    input  wire logic [95:0] s_axis_tdata,
    // recalibrate
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // mean_accel_x, y, z, rate_gyro_x, y, z (16 bits each)
    output logic [95:0]      m_axis_tdata,
    // bias_valid
    output logic             m_axis_tuser
);
    import imavg_pkg::*;

    localparam int SUM_W = SMP_W + $clog2(WINDOW_LEN);
    localparam int ACC_W = SMP_W + $clog2(CAL_SAMPLES);

    logic w_adv;
    logic w_acc;

    t_axes w_smp;
    t_axes w_cell [WINDOW_LEN+1];
    t_axes w_mean;

    logic signed [SUM_W-1:0] r_sum [AXES];
    logic signed [ACC_W-1:0] r_acc [GYRO_AXES];
    logic signed [ACC_W-1:0] w_acc_new [GYRO_AXES];
    t_smp                    r_bias [GYRO_AXES];
    t_smp                    w_bias_q [GYRO_AXES];

    t_phase          r_phase, n_phase, w_ph_in;
    logic [CNT_W-1:0] r_count, n_count, w_cnt_in, w_ccnt_nx;
    t_tag            w_tag;

    logic  r_v1, r_v2, r_v3, r_v4, r_ovld;
    t_tag  r_t1, r_t2, r_t3, r_t4;
    logic  r_div_a, r_div_b;
    t_axes r_mean3, r_mean4, r_out;
    logic  r_obv;

    assign w_adv         = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid && w_adv;

    // window cells
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            w_smp[k] = s_axis_tdata[k*SMP_W +: SMP_W];
        end
    end

    assign w_cell[0] = w_smp;

    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
        imavg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_acc),
            .i_smp   (w_cell[g]),
            .o_smp   (w_cell[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXES; k++) begin
                r_sum[k] <= '0;
            end
        end else if (w_acc) begin
            for (int k = 0; k < AXES; k++) begin
                r_sum[k] <= r_sum[k] + SUM_W'(w_smp[k]) - SUM_W'(w_cell[WINDOW_LEN][k]);
            end
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_mdiv
        imavg_cdiv #(
            .IN_W  (SUM_W),
            .OUT_W (SMP_W),
            .DIV   (WINDOW_LEN)
        ) u_mdiv (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (r_sum[g]),
            .o_quo (w_mean[g])
        );
    end

    // calibration sequencer
    assign w_ph_in   = s_axis_tuser ? PH_WARM : r_phase;
    assign w_cnt_in  = s_axis_tuser ? '0 : r_count;
    assign w_ccnt_nx = ((w_ph_in == PH_CAL) ? w_cnt_in : CNT_W'(0)) + CNT_W'(1);

    always_comb begin
        n_phase = w_ph_in;
        n_count = w_cnt_in;
        case (w_ph_in)
            PH_WARM: begin
                if (w_cnt_in >= CNT_W'(WARMUP_SAMPLES)) begin
                    if (w_ccnt_nx >= CNT_W'(CAL_SAMPLES)) begin
                        n_phase = PH_DONE;
                        n_count = '0;
                    end else begin
                        n_phase = PH_CAL;
                        n_count = w_ccnt_nx;
                    end
                end else begin
                    n_count = w_cnt_in + CNT_W'(1);
                end
            end
            PH_CAL: begin
                if (w_ccnt_nx >= CNT_W'(CAL_SAMPLES)) begin
                    n_phase = PH_DONE;
                    n_count = '0;
                end else begin
                    n_count = w_ccnt_nx;
                end
            end
            default: begin
                n_phase = w_ph_in;
                n_count = w_cnt_in;
            end
        endcase
    end

    always_comb begin
        w_tag.clear  = s_axis_tuser;
        w_tag.bvalid = 1'b0;
        w_tag.cal    = 1'b0;
        case (w_ph_in)
            PH_WARM: w_tag.cal = (w_cnt_in >= CNT_W'(WARMUP_SAMPLES));
            PH_CAL:  w_tag.cal = 1'b1;
            default: w_tag.bvalid = 1'b1;
        endcase
        w_tag.last = w_tag.cal && (w_ccnt_nx >= CNT_W'(CAL_SAMPLES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WARM;
            r_count <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // bias accumulation
    always_comb begin
        for (int k = 0; k < GYRO_AXES; k++) begin
            w_acc_new[k] = (r_t2.clear ? ACC_W'(0) : r_acc[k])
                         + (r_t2.cal ? ACC_W'(w_mean[GYRO_BASE+k]) : ACC_W'(0));
        end
    end

    for (genvar g = 0; g < GYRO_AXES; g++) begin : g_bdiv
        imavg_cdiv #(
            .IN_W  (ACC_W),
            .OUT_W (SMP_W),
            .DIV   (CAL_SAMPLES)
        ) u_bdiv (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (r_acc[g]),
            .o_quo (w_bias_q[g])
        );
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_ovld  <= 1'b0;
            r_div_a <= 1'b0;
            r_div_b <= 1'b0;
            for (int k = 0; k < GYRO_AXES; k++) begin
                r_acc[k]  <= '0;
                r_bias[k] <= '0;
            end
        end else if (w_adv) begin
            r_v1    <= s_axis_tvalid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_ovld  <= r_v4;
            r_div_a <= r_v2 && r_t2.last;
            r_div_b <= r_div_a;
            if (r_v2) begin
                r_acc <= w_acc_new;
            end
            if (r_div_b) begin
                r_bias <= w_bias_q;
            end else if (r_v4 && r_t4.clear) begin
                for (int k = 0; k < GYRO_AXES; k++) begin
                    r_bias[k] <= '0;
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t1    <= w_tag;
            r_t2    <= r_t1;
            r_t3    <= r_t2;
            r_t4    <= r_t3;
            r_mean3 <= w_mean;
            r_mean4 <= r_mean3;
            for (int k = 0; k < GYRO_BASE; k++) begin
                r_out[k] <= r_mean4[k];
            end
            for (int k = 0; k < GYRO_AXES; k++) begin
                r_out[GYRO_BASE+k] <= r_mean4[GYRO_BASE+k]
                                    - (r_t4.clear ? SMP_W'(0) : r_bias[k]);
            end
            r_obv <= r_t4.bvalid;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tuser  = r_obv;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            m_axis_tdata[k*SMP_W +: SMP_W] = r_out[k];
        end
    end

endmodule
`default_nettype wire
